[design/rwpc_pkg.sv]
// ----------------------------------------------------------------------------
// rwpc_pkg: shared types and constants for rectangle pixel coverage
// Fixed-point widths, register indexes, corner codes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rwpc_pkg;

    // fixed-point layout
    localparam int FRAC_BITS  = 16;
    localparam int EDGE_SHIFT = FRAC_BITS + 1;
    localparam int CENTER_W   = 29;
    localparam int COORD_W    = CENTER_W + 1 - FRAC_BITS;
    localparam int EDGE_W     = 32;
    localparam int IPIX_W     = EDGE_W - EDGE_SHIFT;
    localparam int WX_W       = EDGE_SHIFT + 1;
    localparam int AREA_W     = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * WX_W;
    localparam int PIX_W      = 12;
    localparam int ITEM_W     = 16;
    localparam int DIM_W      = 23;
    localparam int SIDE_W     = 13;
    localparam int PAD_W      = 2;

    // clipping limits
    localparam logic [PAD_W-1:0]  MAX_PADDING    = 2'd3;
    localparam logic [SIDE_W-1:0] MAX_IMAGE_SIDE = 13'd4096;

    // area of a fully covered pixel
    localparam logic [AREA_W-1:0] AREA_FULL = AREA_W'(1) << FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PADDING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT    = 3'd4;

    // reset values of the registers
    localparam logic [PAD_W-1:0]  RST_PADDING = 2'd1;
    localparam logic [SIDE_W-1:0] RST_SIDE    = 13'd2048;
    localparam logic [DIM_W-1:0]  RST_DIM     = DIM_W'(1) << FRAC_BITS;

    // corner product codes: bit 1 picks the right column, bit 0 the top row
    localparam int CORNER_W = 2;
    localparam logic [CORNER_W-1:0] CORNER_LB = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_LT = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_RB = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_RT = 2'd3;

    // commands from the controller
    typedef struct packed {
        logic                load;
        logic                step_a;
        logic                step_b;
        logic                step_c;
        logic                corner;
        logic [CORNER_W-1:0] corner_sel;
        logic                emit;
    } ctrl_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic outside;
        logic empty;
        logic last;
        logic out_free;
    } ctrl_status_t;

endpackage

[design/rwpc_ctrl.sv]
// ----------------------------------------------------------------------------
// rwpc_ctrl: sequencer for rectangle pixel coverage
// Steps one rectangle through setup, corner products and the pixel scan.
// ----------------------------------------------------------------------------
module rwpc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rwpc_pkg::ctrl_status_t status,
    output rwpc_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETUPA = 6'b000010,
        ST_SETUPB = 6'b000100,
        ST_SETUPC = 6'b001000,
        ST_CORNER = 6'b010000,
        ST_SCAN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [rwpc_pkg::CORNER_W-1:0] corner_cnt_reg, corner_cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        corner_cnt_next = corner_cnt_reg;
        cmd             = '0;
        cmd.corner_sel  = corner_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUPA;
                end
            end
            ST_SETUPA: begin
                cmd.step_a = 1'b1;
                state_next = ST_SETUPB;
            end
            ST_SETUPB: begin
                if (status.outside) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.step_b = 1'b1;
                    state_next = ST_SETUPC;
                end
            end
            ST_SETUPC: begin
                cmd.step_c      = 1'b1;
                corner_cnt_next = rwpc_pkg::CORNER_LB;
                state_next      = ST_CORNER;
            end
            ST_CORNER: begin
                if (status.empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.corner      = 1'b1;
                    corner_cnt_next = corner_cnt_reg + rwpc_pkg::CORNER_W'(1);
                    if (corner_cnt_reg == rwpc_pkg::CORNER_RT) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            corner_cnt_reg <= rwpc_pkg::CORNER_LB;
        end else begin
            state_reg      <= state_next;
            corner_cnt_reg <= corner_cnt_next;
        end
    end

endmodule

[design/rwpc_datapath.sv]
// ----------------------------------------------------------------------------
// rwpc_datapath: window clipping, edge weights and pixel scan
// Holds the configuration registers, the per-rectangle setup registers, a
// shared corner multiplier, the scan counters and the output register.
// ----------------------------------------------------------------------------
module rwpc_datapath (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration
    input  logic                                       cfg_write,
    input  logic [rwpc_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [rwpc_pkg::CFG_DATA_W-1:0]            cfg_data,
    // input payload
    input  logic signed [rwpc_pkg::CENTER_W-1:0]       s_center_x,
    input  logic signed [rwpc_pkg::CENTER_W-1:0]       s_center_y,
    input  logic [rwpc_pkg::ITEM_W-1:0]                s_item_number,
    // controller link
    input  rwpc_pkg::ctrl_cmd_t                        cmd,
    output rwpc_pkg::ctrl_status_t                     status,
    // result channel
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [rwpc_pkg::PIX_W-1:0]                 m_pixel_x,
    output logic [rwpc_pkg::PIX_W-1:0]                 m_pixel_y,
    output logic [rwpc_pkg::AREA_W-1:0]                m_covered_area,
    output logic [rwpc_pkg::ITEM_W-1:0]                m_source_item,
    output logic                                       m_last_pixel
);

    localparam int CW   = rwpc_pkg::CENTER_W;
    localparam int CRW  = rwpc_pkg::COORD_W;
    localparam int EW   = rwpc_pkg::EDGE_W;
    localparam int ES   = rwpc_pkg::EDGE_SHIFT;
    localparam int IW   = rwpc_pkg::IPIX_W;
    localparam int WW   = rwpc_pkg::WX_W;
    localparam int AW   = rwpc_pkg::AREA_W;
    localparam int PW   = rwpc_pkg::PIX_W;
    localparam int FB   = rwpc_pkg::FRAC_BITS;
    localparam int DW   = rwpc_pkg::DIM_W;
    localparam int SW   = rwpc_pkg::SIDE_W;
    localparam int PDW  = rwpc_pkg::PAD_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [PDW-1:0] padding_reg;
    logic [SW-1:0]  img_w_reg, img_h_reg;
    logic [DW-1:0]  rect_w_reg, rect_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            padding_reg <= rwpc_pkg::RST_PADDING;
            img_w_reg   <= rwpc_pkg::RST_SIDE;
            img_h_reg   <= rwpc_pkg::RST_SIDE;
            rect_w_reg  <= rwpc_pkg::RST_DIM;
            rect_h_reg  <= rwpc_pkg::RST_DIM;
        end else if (cfg_write) begin
            unique case (cfg_index)
                rwpc_pkg::CFG_WINDOW_PADDING: padding_reg <= cfg_data[PDW-1:0];
                rwpc_pkg::CFG_IMAGE_WIDTH:    img_w_reg   <= cfg_data[SW-1:0];
                rwpc_pkg::CFG_IMAGE_HEIGHT:   img_h_reg   <= cfg_data[SW-1:0];
                rwpc_pkg::CFG_RECT_WIDTH:     rect_w_reg  <= cfg_data[DW-1:0];
                rwpc_pkg::CFG_RECT_HEIGHT:    rect_h_reg  <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // effective limits
    logic [PDW-1:0]        pad_eff;
    logic [SW-1:0]         img_w_eff, img_h_eff;
    logic signed [CRW-1:0] pad_s, nx1, ny1;

    always_comb begin
        pad_eff   = (padding_reg > rwpc_pkg::MAX_PADDING) ? rwpc_pkg::MAX_PADDING : padding_reg;
        img_w_eff = (img_w_reg > rwpc_pkg::MAX_IMAGE_SIDE) ? rwpc_pkg::MAX_IMAGE_SIDE : img_w_reg;
        img_h_eff = (img_h_reg > rwpc_pkg::MAX_IMAGE_SIDE) ? rwpc_pkg::MAX_IMAGE_SIDE : img_h_reg;
        pad_s     = $signed(CRW'(pad_eff));
        nx1       = $signed(CRW'(img_w_eff)) - $signed(CRW'(1));
        ny1       = $signed(CRW'(img_h_eff)) - $signed(CRW'(1));
    end

    // ------------------------------------------------------------------
    // input capture
    // ------------------------------------------------------------------
    logic signed [CW-1:0]            cx_reg, cy_reg;
    logic [rwpc_pkg::ITEM_W-1:0]     item_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg   <= s_center_x;
            cy_reg   <= s_center_y;
            item_reg <= s_item_number;
        end
    end

    // ------------------------------------------------------------------
    // setup a: centre pixel, window bounds, exact rectangle edges
    // ------------------------------------------------------------------
    logic signed [CW:0]    bias_x, bias_y, sum_x, sum_y;
    logic signed [CRW-1:0] ix, iy, wl, wr, wb, wt;
    logic signed [EW-1:0]  cx_ext, cy_ext, w_ext, h_ext;
    logic                  outside_a;

    logic signed [CRW-1:0] l_reg, r_reg, b_reg, t_reg;
    logic signed [EW-1:0]  x1_reg, x2_reg, y1_reg, y2_reg;
    logic                  outside_reg;

    always_comb begin
        // truncate toward zero: bias negative values before the floor
        bias_x = $signed({{(CW + 1 - FB){1'b0}}, {FB{cx_reg[CW-1]}}});
        bias_y = $signed({{(CW + 1 - FB){1'b0}}, {FB{cy_reg[CW-1]}}});
        sum_x  = $signed({cx_reg[CW-1], cx_reg}) + bias_x;
        sum_y  = $signed({cy_reg[CW-1], cy_reg}) + bias_y;
        ix     = $signed(sum_x[CW:FB]);
        iy     = $signed(sum_y[CW:FB]);
        wl     = ix - pad_s;
        wr     = ix + pad_s;
        wb     = iy - pad_s;
        wt     = iy + pad_s;
        outside_a = (wl > nx1) || (wr < 0) || (wb > ny1) || (wt < 0);
        cx_ext = $signed({{(EW - CW){cx_reg[CW-1]}}, cx_reg});
        cy_ext = $signed({{(EW - CW){cy_reg[CW-1]}}, cy_reg});
        w_ext  = $signed({{(EW - DW){1'b0}}, rect_w_reg});
        h_ext  = $signed({{(EW - DW){1'b0}}, rect_h_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_a) begin
            l_reg       <= (wl < 0) ? '0 : wl;
            r_reg       <= (wr > nx1) ? nx1 : wr;
            b_reg       <= (wb < 0) ? '0 : wb;
            t_reg       <= (wt > ny1) ? ny1 : wt;
            x1_reg      <= (cx_ext <<< 1) - w_ext;
            x2_reg      <= (cx_ext <<< 1) + w_ext;
            y1_reg      <= (cy_ext <<< 1) - h_ext;
            y2_reg      <= (cy_ext <<< 1) + h_ext;
            outside_reg <= outside_a;
        end
    end

    // ------------------------------------------------------------------
    // setup b: first and last pixel per axis, clamped to the window
    // ------------------------------------------------------------------
    logic signed [EW-1:0] x2m1, y2m1;
    logic signed [IW-1:0] imin_raw, imax_raw, jmin_raw, jmax_raw;
    logic signed [IW-1:0] l_i, r_i, b_i, t_i;
    logic signed [EW-1:0] l_e, r1_e, b_e, t1_e;

    logic signed [IW-1:0] imin_reg, imax_reg, jmin_reg, jmax_reg;
    logic signed [EW-1:0] x1c_reg, x2c_reg, y1c_reg, y2c_reg;

    always_comb begin
        x2m1     = x2_reg - $signed(EW'(1));
        y2m1     = y2_reg - $signed(EW'(1));
        imin_raw = $signed(x1_reg[EW-1:ES]);
        imax_raw = $signed(x2m1[EW-1:ES]);
        jmin_raw = $signed(y1_reg[EW-1:ES]);
        jmax_raw = $signed(y2m1[EW-1:ES]);
        l_i      = $signed({l_reg[CRW-1], l_reg});
        r_i      = $signed({r_reg[CRW-1], r_reg});
        b_i      = $signed({b_reg[CRW-1], b_reg});
        t_i      = $signed({t_reg[CRW-1], t_reg});
        l_e      = $signed({{(EW - CRW){l_reg[CRW-1]}}, l_reg}) <<< ES;
        b_e      = $signed({{(EW - CRW){b_reg[CRW-1]}}, b_reg}) <<< ES;
        r1_e     = ($signed({{(EW - CRW){r_reg[CRW-1]}}, r_reg}) + $signed(EW'(1))) <<< ES;
        t1_e     = ($signed({{(EW - CRW){t_reg[CRW-1]}}, t_reg}) + $signed(EW'(1))) <<< ES;
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_b) begin
            if (imin_raw < l_i) begin
                imin_reg <= l_i;
                x1c_reg  <= l_e;
            end else begin
                imin_reg <= imin_raw;
                x1c_reg  <= x1_reg;
            end
            if (imax_raw > r_i) begin
                imax_reg <= r_i;
                x2c_reg  <= r1_e;
            end else begin
                imax_reg <= imax_raw;
                x2c_reg  <= x2_reg;
            end
            if (jmin_raw < b_i) begin
                jmin_reg <= b_i;
                y1c_reg  <= b_e;
            end else begin
                jmin_reg <= jmin_raw;
                y1c_reg  <= y1_reg;
            end
            if (jmax_raw > t_i) begin
                jmax_reg <= t_i;
                y2c_reg  <= t1_e;
            end else begin
                jmax_reg <= jmax_raw;
                y2c_reg  <= y2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // setup c: empty check and edge weights
    // ------------------------------------------------------------------
    logic signed [EW-1:0] xb_e, yb_e, xr_e, yt_e;
    logic signed [EW-1:0] wx1_full, wx2_full, wy1_full, wy2_full;

    logic [WW-1:0] wx1_reg, wx2_reg, wy1_reg, wy2_reg;
    logic          empty_reg;

    always_comb begin
        xb_e = ($signed({{(EW - IW){imin_reg[IW-1]}}, imin_reg}) + $signed(EW'(1))) <<< ES;
        yb_e = ($signed({{(EW - IW){jmin_reg[IW-1]}}, jmin_reg}) + $signed(EW'(1))) <<< ES;
        xr_e = $signed({{(EW - IW){imax_reg[IW-1]}}, imax_reg}) <<< ES;
        yt_e = $signed({{(EW - IW){jmax_reg[IW-1]}}, jmax_reg}) <<< ES;
        wx1_full = (x2c_reg > xb_e) ? (xb_e - x1c_reg) : (x2c_reg - x1c_reg);
        wy1_full = (y2c_reg > yb_e) ? (yb_e - y1c_reg) : (y2c_reg - y1c_reg);
        wx2_full = x2c_reg - xr_e;
        wy2_full = y2c_reg - yt_e;
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_c) begin
            wx1_reg   <= wx1_full[WW-1:0];
            wx2_reg   <= wx2_full[WW-1:0];
            wy1_reg   <= wy1_full[WW-1:0];
            wy2_reg   <= wy2_full[WW-1:0];
            empty_reg <= (x1c_reg >= x2c_reg) || (y1c_reg >= y2c_reg);
        end
    end

    // ------------------------------------------------------------------
    // corner products through one shared multiplier
    // ------------------------------------------------------------------
    logic [WW-1:0]                 mul_a, mul_b;
    logic [rwpc_pkg::PROD_W-1:0]   mul_p;
    logic [AW-1:0]                 corner_reg [4];

    always_comb begin
        mul_a = cmd.corner_sel[1] ? wx2_reg : wx1_reg;
        mul_b = cmd.corner_sel[0] ? wy2_reg : wy1_reg;
        mul_p = rwpc_pkg::PROD_W'(mul_a) * rwpc_pkg::PROD_W'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (cmd.corner) begin
            corner_reg[cmd.corner_sel] <= mul_p[AW + FB + 1:FB + 2];
        end
    end

    // ------------------------------------------------------------------
    // pixel scan: left column takes its top corner second
    // ------------------------------------------------------------------
    logic [PW-1:0] cur_i_reg, cur_j_reg;
    logic          top_done_reg;
    logic [PW-1:0] imin_p, imax_p, jmin_p, jmax_p, j_after;
    logic          is_left, is_right, is_bot, is_top, single_row, col_end, last;
    logic [AW-1:0] area;

    always_comb begin
        imin_p     = imin_reg[PW-1:0];
        imax_p     = imax_reg[PW-1:0];
        jmin_p     = jmin_reg[PW-1:0];
        jmax_p     = jmax_reg[PW-1:0];
        is_left    = (cur_i_reg == imin_p);
        is_right   = (cur_i_reg == imax_p);
        is_bot     = (cur_j_reg == jmin_p);
        is_top     = (cur_j_reg == jmax_p);
        single_row = (jmin_p == jmax_p);
        j_after    = is_top ? (jmin_p + PW'(1)) : (cur_j_reg + PW'(1));
        if (is_left) begin
            col_end = single_row || (top_done_reg && (j_after == jmax_p));
        end else begin
            col_end = is_top;
        end
        last = col_end && is_right;

        // covered area by column and row kind
        if (is_left) begin
            if (is_bot)      area = corner_reg[rwpc_pkg::CORNER_LB];
            else if (is_top) area = corner_reg[rwpc_pkg::CORNER_LT];
            else             area = wx1_reg[WW-1:1];
        end else if (is_right) begin
            if (is_bot)      area = corner_reg[rwpc_pkg::CORNER_RB];
            else if (is_top) area = corner_reg[rwpc_pkg::CORNER_RT];
            else             area = wx2_reg[WW-1:1];
        end else begin
            if (is_bot)      area = wy1_reg[WW-1:1];
            else if (is_top) area = wy2_reg[WW-1:1];
            else             area = rwpc_pkg::AREA_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_c) begin
            cur_i_reg    <= imin_reg[PW-1:0];
            cur_j_reg    <= jmin_reg[PW-1:0];
            top_done_reg <= 1'b0;
        end else if (cmd.emit) begin
            if (col_end) begin
                cur_i_reg    <= cur_i_reg + PW'(1);
                cur_j_reg    <= jmin_p;
                top_done_reg <= 1'b0;
            end else if (is_left && !top_done_reg) begin
                cur_j_reg    <= jmax_p;
                top_done_reg <= 1'b1;
            end else begin
                cur_j_reg    <= j_after;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_pixel_x      <= cur_i_reg;
            m_pixel_y      <= cur_j_reg;
            m_covered_area <= area;
            m_source_item  <= item_reg;
            m_last_pixel   <= last;
        end
    end

    assign m_valid = m_valid_reg;

    // status to the controller
    always_comb begin
        status          = '0;
        status.outside  = outside_reg;
        status.empty    = empty_reg;
        status.last     = last;
        status.out_free = !m_valid_reg || m_ready;
    end

endmodule

[design/rect_window_pixel_coverage.sv]
// ----------------------------------------------------------------------------
// rect_window_pixel_coverage: pixel area coverage of a placed rectangle
// Each input beat carries a rectangle centre; the block emits one beat per
// covered pixel with its area, the item number and a last-pixel flag.
//
// Each centre (signed, 16 fraction bits) is truncated to a pixel, a window of
// +/- window_padding pixels around it is clipped to the image, and a
// rectangle of rect_width x rect_height is clipped to that window. Covered
// pixels come out column by column from the left: in the leftmost column the
// bottom corner, then the top corner, then the rows between; in every other
// column bottom to top. The last beat of a rectangle has m_last_pixel set;
// a rectangle that misses the window or the image produces no beat at all.
// Items are handled one at a time: after acceptance the controller runs
// three clipping stages and four passes through the single shared corner
// multiplier, then spends one cycle per pixel (1 to 49) while the output is
// not stalled, and returns to idle before the next beat is taken. A window
// that misses the image retires from setup b and a rectangle that misses
// its window from the corner state. The last pixel waits in the output
// register while the next item is already accepted. The user must write the
// configuration registers over the cfg channel only while no item is in
// flight; the block does not enforce this, and cfg_ready is always high.
// ----------------------------------------------------------------------------
module rect_window_pixel_coverage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rwpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rwpc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // rectangle input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rwpc_pkg::CENTER_W-1:0]  s_center_x,
    input  logic signed [rwpc_pkg::CENTER_W-1:0]  s_center_y,
    input  logic [rwpc_pkg::ITEM_W-1:0]           s_item_number,
    // pixel result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rwpc_pkg::PIX_W-1:0]            m_pixel_x,
    output logic [rwpc_pkg::PIX_W-1:0]            m_pixel_y,
    output logic [rwpc_pkg::AREA_W-1:0]           m_covered_area,
    output logic [rwpc_pkg::ITEM_W-1:0]           m_source_item,
    output logic                                  m_last_pixel
);

    rwpc_pkg::ctrl_cmd_t    cmd;
    rwpc_pkg::ctrl_status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    rwpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // clipping, weights, scan and output register
    rwpc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_item_number  (s_item_number),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_covered_area (m_covered_area),
        .m_source_item  (m_source_item),
        .m_last_pixel   (m_last_pixel)
    );

endmodule
